/* rtl/kesl_pkg.sv */
// ----------------------------------------------------------------------------
// kesl_pkg
// shared types and constants of the kinetic energy slope limiter
// ----------------------------------------------------------------------------
package kesl_pkg;

    localparam logic [16:0] ONE_Q16   = 17'd65536;
    localparam logic [23:0] RATIO_SAT = 24'hFFFFFF;
    localparam logic [23:0] ALPHA_SAT = 24'd65536;

    // limiter modes
    localparam logic [1:0] MODE_BJ    = 2'd0;
    localparam logic [1:0] MODE_VK    = 2'd1;
    localparam logic [1:0] MODE_FIRST = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    // item actions
    localparam logic [1:0] ACT_MEAN   = 2'd0;
    localparam logic [1:0] ACT_NBR    = 2'd1;
    localparam logic [1:0] ACT_SAMPLE = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] total_energy;
        logic [16:0]        energy_limit;
        logic               last;
    } t_in;

    typedef struct packed {
        logic signed [31:0] lim_x;
        logic signed [31:0] lim_y;
        logic signed [31:0] lim_z;
        logic [16:0]        coefficient;
        logic               final_res;
    } t_out;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
        logic [23:0] sat;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [23:0] quot;
    } t_div_rsp;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SQX,
        S_SQY,
        S_SQZ,
        S_KE,
        S_RATIO,
        S_RWAIT,
        S_LIMIT,
        S_VKDIV,
        S_VKWAIT,
        S_FOLD,
        S_PWAIT,
        S_STORE,
        S_RD,
        S_EX,
        S_EY,
        S_EZ,
        S_PUT
    } t_state;

endpackage

/* rtl/kesl_div.sv */
// ----------------------------------------------------------------------------
// kesl_div
// sequential q16 divider: min(floor(num * 2^16 / den), sat), one bit a cycle
// ----------------------------------------------------------------------------
module kesl_div
    import kesl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic        r_run;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [63:0] r_rem;
    logic [24:0] r_sh;
    logic [24:0] r_q;
    logic [63:0] r_den;
    logic [23:0] r_sat;
    logic [23:0] r_quot;

    logic [64:0] rem2;
    logic        ge;
    logic [64:0] rem_sub;
    logic [24:0] q_next;

    assign rem2    = {r_rem, r_sh[24]};
    assign ge      = rem2 >= {1'b0, r_den};
    assign rem_sub = rem2 - {1'b0, r_den};
    assign q_next  = {r_q[23:0], ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_den <= i_req.den;
                r_sat <= i_req.sat;
                // quotient at or above 2^25 always saturates
                if ((i_req.num >> 9) >= i_req.den) begin
                    r_quot <= i_req.sat;
                    r_done <= 1'b1;
                end else begin
                    r_rem <= i_req.num >> 9;
                    r_sh  <= {i_req.num[8:0], 16'b0};
                    r_q   <= '0;
                    r_cnt <= '0;
                    r_run <= 1'b1;
                end
            end else if (r_run) begin
                r_rem <= ge ? rem_sub[63:0] : rem2[63:0];
                r_sh  <= {r_sh[23:0], 1'b0};
                r_q   <= q_next;
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd24) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                    r_quot <= (q_next > {1'b0, r_sat}) ? r_sat : q_next[23:0];
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

/* rtl/kinetic_energy_slope_limiter_top.sv */
// ----------------------------------------------------------------------------
// kinetic_energy_slope_limiter_top
// velocity slope limiter of one element, kinetic energy based, fixed point
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy stays high until
// the item is fully worked off. One 33x33 multiplier and one 25-step divider
// are shared under a small sequencer. Averages pass the three squares and the
// energy step. A sample goes on to up to three divisions (ratio, the
// Venkatakrishnan quotient in mode 1, positivity bound) and waits on the
// divider for each; a saturating quotient returns early. The sample marked
// last then emits one result per stored point (memory read, three multiplies
// and the output step). Results come out on a single-cycle strobe and cannot
// be stalled: the receiver must take every result the cycle it appears. The
// mode register is written only while busy is low and no item is being
// offered.
module kinetic_energy_slope_limiter_top
    import kesl_pkg::*;
#(
    parameter int MAX_POINTS = 8,
    parameter int VEL_BITS   = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_in        i_item,
    output logic       o_res_strobe,
    output t_out       o_res,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_data
);

    localparam int SH    = 32 - VEL_BITS;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    t_state r_state, n_state;

    // latched item, velocities sign-extended from VEL_BITS
    logic signed [31:0] r_vx, r_vy, r_vz;
    logic signed [31:0] r_energy;
    logic [16:0]        r_elim;
    logic               r_last;
    logic [1:0]         r_action;

    logic [1:0]         r_mode;

    // element state
    logic signed [31:0] r_mean_x, r_mean_y, r_mean_z;
    logic [63:0]        r_emean, r_ehigh, r_elow;
    logic [16:0]        r_run_alpha;
    logic [CNT_W-1:0]   r_count;

    // working registers
    logic [63:0]        r_acc;
    logic [63:0]        r_ke;
    logic signed [63:0] r_prod;
    logic [23:0]        r_ratio;
    logic [16:0]        r_lim_alpha;
    logic [CNT_W-1:0]   r_idx;
    logic signed [31:0] r_lx, r_ly;

    // point store
    logic [95:0]        r_mem [MAX_POINTS];
    logic [95:0]        r_rd;

    t_out               r_res;
    logic               r_res_strobe;

    t_div_req           div_req;
    t_div_rsp           div_rsp;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;

    logic signed [31:0] sx, sy, sz;
    logic [63:0]        ke_sum, ke_half, ke_val;
    logic signed [64:0] ke_diff;
    logic               go_up, go_down;
    logic [63:0]        r2;
    logic [16:0]        fold_alpha;
    logic               pos_zero;
    logic               last_pt;
    logic signed [31:0] rd_x, rd_y, rd_z;
    logic signed [31:0] blend_off;

    kesl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // sign extension of the low VEL_BITS bits
    assign sx = $signed(i_item.vel_x <<< SH) >>> SH;
    assign sy = $signed(i_item.vel_y <<< SH) >>> SH;
    assign sz = $signed(i_item.vel_z <<< SH) >>> SH;

    assign busy        = (r_state != S_IDLE);
    // mode changes only between items, never while one is in flight
    assign o_cfg_ready = !busy && !start;

    assign rd_x = r_rd[95:64];
    assign rd_y = r_rd[63:32];
    assign rd_z = r_rd[31:0];

    // kinetic energy, halved and floored at one lsb
    assign ke_sum  = r_acc + r_prod;
    assign ke_half = ke_sum >> 1;
    assign ke_val  = (ke_half == 64'd0) ? 64'd1 : ke_half;

    assign ke_diff = $signed({1'b0, r_ke}) - $signed({1'b0, r_emean});
    assign go_up   = ke_diff > 65'sd1;
    assign go_down = ke_diff < -65'sd1;

    assign r2 = r_prod;

    // fold of limiter value and energy limiter into the running minimum
    always_comb begin
        fold_alpha = r_run_alpha;
        if (r_lim_alpha < fold_alpha) begin
            fold_alpha = r_lim_alpha;
        end
        if (r_elim < fold_alpha) begin
            fold_alpha = r_elim;
        end
    end

    assign pos_zero  = (r_energy == 32'sd0) || r_energy[31];
    assign last_pt   = (r_idx + CNT_W'(1)) == r_count;
    assign blend_off = r_prod[47:16];

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_SQX: begin
                mul_a = 33'(r_vx);
                mul_b = 33'(r_vx);
            end
            S_SQY: begin
                mul_a = 33'(r_vy);
                mul_b = 33'(r_vy);
            end
            S_SQZ: begin
                mul_a = 33'(r_vz);
                mul_b = 33'(r_vz);
            end
            S_LIMIT: begin
                mul_a = $signed({9'b0, r_ratio});
                mul_b = $signed({9'b0, r_ratio});
            end
            S_EX: begin
                mul_a = 33'(rd_x) - 33'(r_mean_x);
                mul_b = $signed({16'b0, r_run_alpha});
            end
            S_EY: begin
                mul_a = 33'(rd_y) - 33'(r_mean_y);
                mul_b = $signed({16'b0, r_run_alpha});
            end
            S_EZ: begin
                mul_a = 33'(rd_z) - 33'(r_mean_z);
                mul_b = $signed({16'b0, r_run_alpha});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // next state and divider requests
    always_comb begin
        n_state       = r_state;
        div_req.start = 1'b0;
        div_req.num   = '0;
        div_req.den   = 64'd1;
        div_req.sat   = ALPHA_SAT;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_SQX;
                end
            end
            S_SQX: n_state = S_SQY;
            S_SQY: n_state = S_SQZ;
            S_SQZ: n_state = S_KE;
            S_KE: begin
                n_state = (r_action == ACT_SAMPLE) ? S_RATIO : S_IDLE;
            end
            S_RATIO: begin
                div_req.sat = RATIO_SAT;
                if (go_up) begin
                    div_req.start = 1'b1;
                    div_req.num   = (r_ehigh > r_emean) ? r_ehigh - r_emean : 64'd0;
                    div_req.den   = ke_diff[63:0];
                    n_state       = S_RWAIT;
                end else if (go_down) begin
                    div_req.start = 1'b1;
                    div_req.num   = (r_emean > r_elow) ? r_emean - r_elow : 64'd0;
                    div_req.den   = r_emean - r_ke;
                    n_state       = S_RWAIT;
                end else begin
                    n_state = S_LIMIT;
                end
            end
            S_RWAIT: begin
                if (div_rsp.done) begin
                    n_state = S_LIMIT;
                end
            end
            S_LIMIT: begin
                n_state = (r_mode == MODE_VK) ? S_VKDIV : S_FOLD;
            end
            S_VKDIV: begin
                div_req.start = 1'b1;
                div_req.num   = r2 + {23'b0, r_ratio, 17'b0};
                div_req.den   = r2 + {24'b0, r_ratio, 16'b0} + 64'h2_0000_0000;
                n_state       = S_VKWAIT;
            end
            S_VKWAIT: begin
                if (div_rsp.done) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                if (pos_zero) begin
                    n_state = S_STORE;
                end else begin
                    div_req.start = 1'b1;
                    div_req.num   = {16'b0, r_energy, 16'b0};
                    div_req.den   = r_ke + 64'd1;
                    n_state       = S_PWAIT;
                end
            end
            S_PWAIT: begin
                if (div_rsp.done) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: n_state = r_last ? S_RD : S_IDLE;
            S_RD:    n_state = S_EX;
            S_EX:    n_state = S_EY;
            S_EY:    n_state = S_EZ;
            S_EZ:    n_state = S_PUT;
            S_PUT:   n_state = last_pt ? S_IDLE : S_RD;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_BJ;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mode <= i_cfg_data;
        end
    end

    // element state and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean_x     <= '0;
            r_mean_y     <= '0;
            r_mean_z     <= '0;
            r_emean      <= '0;
            r_ehigh      <= '0;
            r_elow       <= '0;
            r_run_alpha  <= ONE_Q16;
            r_count      <= '0;
            r_idx        <= '0;
            r_res_strobe <= 1'b0;
        end else begin
            r_res_strobe <= 1'b0;
            case (r_state)
                S_KE: begin
                    if (r_action == ACT_MEAN) begin
                        // new element, any unfinished one is dropped
                        r_mean_x    <= r_vx;
                        r_mean_y    <= r_vy;
                        r_mean_z    <= r_vz;
                        r_emean     <= ke_val;
                        r_ehigh     <= ke_val;
                        r_elow      <= ke_val;
                        r_run_alpha <= ONE_Q16;
                        r_count     <= '0;
                    end else if (r_action == ACT_NBR) begin
                        if (ke_val > r_ehigh) begin
                            r_ehigh <= ke_val;
                        end
                        if (ke_val < r_elow) begin
                            r_elow <= ke_val;
                        end
                    end
                end
                S_FOLD: begin
                    r_run_alpha <= pos_zero ? 17'd0 : fold_alpha;
                end
                S_PWAIT: begin
                    if (div_rsp.done && (div_rsp.quot < {7'b0, r_run_alpha})) begin
                        r_run_alpha <= div_rsp.quot[16:0];
                    end
                end
                S_STORE: begin
                    // full store: the sample still tightens the coefficient
                    if (r_count < CNT_W'(MAX_POINTS)) begin
                        r_count <= r_count + CNT_W'(1);
                    end
                    r_idx <= '0;
                end
                S_PUT: begin
                    r_res_strobe <= 1'b1;
                    r_idx        <= r_idx + CNT_W'(1);
                    if (last_pt) begin
                        r_run_alpha <= ONE_Q16;
                        r_count     <= '0;
                        r_idx       <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p[63:0];
        if (r_state == S_IDLE && start) begin
            r_action <= i_item.action;
            r_vx     <= sx;
            r_vy     <= sy;
            r_vz     <= sz;
            r_energy <= i_item.total_energy;
            r_elim   <= i_item.energy_limit;
            r_last   <= i_item.last;
        end
        case (r_state)
            S_SQY: r_acc <= r_prod;
            S_SQZ: r_acc <= r_acc + r_prod;
            S_KE:  r_ke  <= ke_val;
            S_RATIO: begin
                r_ratio <= {7'b0, ONE_Q16};
            end
            S_RWAIT: begin
                if (div_rsp.done) begin
                    r_ratio <= div_rsp.quot;
                end
            end
            S_LIMIT: begin
                case (r_mode)
                    MODE_BJ: begin
                        r_lim_alpha <= (r_ratio > {7'b0, ONE_Q16}) ? ONE_Q16
                                                                   : r_ratio[16:0];
                    end
                    MODE_FIRST: r_lim_alpha <= 17'd0;
                    default:    r_lim_alpha <= ONE_Q16;
                endcase
            end
            S_VKWAIT: begin
                if (div_rsp.done) begin
                    r_lim_alpha <= div_rsp.quot[16:0];
                end
            end
            S_EY: r_lx <= r_mean_x + blend_off;
            S_EZ: r_ly <= r_mean_y + blend_off;
            S_PUT: begin
                r_res.lim_x       <= r_lx;
                r_res.lim_y       <= r_ly;
                r_res.lim_z       <= r_mean_z + blend_off;
                r_res.coefficient <= r_run_alpha;
                r_res.final_res   <= last_pt;
            end
            default: begin
            end
        endcase
    end

    // point store memory
    always_ff @(posedge i_clk) begin
        if (r_state == S_STORE && r_count < CNT_W'(MAX_POINTS)) begin
            r_mem[r_count[IDX_W-1:0]] <= {r_vx, r_vy, r_vz};
        end
        r_rd <= r_mem[r_idx[IDX_W-1:0]];
    end

    assign o_res_strobe = r_res_strobe;
    assign o_res        = r_res;

`ifndef SYNTHESIS
    // a result only follows the output step of the emit walk
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_strobe |-> $past(r_state == S_PUT))
        else $error("result strobe outside emit walk");

    // coefficient never exceeds one
    a_coef_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_strobe |-> (r_res.coefficient <= ONE_Q16))
        else $error("coefficient above one");

    // store fill never passes its depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_POINTS))
        else $error("point count overflow");

    // the running minimum is back at one once the element closes
    a_alpha_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUT && last_pt) |=> (r_run_alpha == ONE_Q16 && r_count == '0))
        else $error("element state not cleared after last result");
`endif

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the kinetic energy slope limiter: a scoreboard
// predicts the limited velocities of every element and checks each result
// ----------------------------------------------------------------------------
import kesl_pkg::*;

class limiter_scoreboard;
    logic [1:0]   mode;
    longint       mx, my, mz;
    longint unsigned e_mean, e_high, e_low;
    longint unsigned alpha_run;
    longint       px[8], py[8], pz[8];
    int           npts;
    t_out         pending[$];
    int           errors;

    function new();
        mode = MODE_BJ;
        mx = 0; my = 0; mz = 0;
        e_mean = 0; e_high = 0; e_low = 0;
        alpha_run = 65536;
        npts = 0;
        errors = 0;
    endfunction

    function longint unsigned energy_of(longint x, longint y, longint z);
        longint unsigned s;
        s = longint'(x * x) + longint'(y * y) + longint'(z * z);
        s = s >> 1;
        return (s < 1) ? 1 : s;
    endfunction

    // truncated q16 quotient, saturated
    function longint unsigned quot_q16(longint unsigned num, longint unsigned den,
                                       longint unsigned sat);
        longint unsigned q, r;
        q = num / den;
        r = num % den;
        if (q > (sat >> 16)) return sat;
        for (int i = 0; i < 16; i++) begin
            q = q << 1;
            r = r << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 1;
            end
        end
        return (q > sat) ? sat : q;
    endfunction

    function longint unsigned shape(longint unsigned r);
        longint unsigned r2;
        case (mode)
            MODE_BJ: return (r > 65536) ? 65536 : r;
            MODE_VK: begin
                r2 = r * r;
                return quot_q16(r2 + (r << 17), r2 + (r << 16) + (64'd2 << 32), 65536);
            end
            MODE_FIRST: return 0;
            default: return 65536;
        endcase
    endfunction

    function longint mix(longint m, longint v, longint unsigned a);
        longint p, q;
        p = (v - m) * longint'(a);
        q = p / 65536;
        if (p < 0 && p % 65536 != 0) q = q - 1;
        return m + q;
    endfunction

    // note one accepted item and queue the results it causes
    function void note_item(t_in it);
        longint x, y, z;
        longint unsigned ke, ratio, a, eraw;
        t_out r;
        x = it.vel_x; y = it.vel_y; z = it.vel_z;
        ke = energy_of(x, y, z);
        if (it.action == ACT_MEAN) begin
            mx = x; my = y; mz = z;
            e_mean = ke; e_high = ke; e_low = ke;
            alpha_run = 65536;
            npts = 0;
            return;
        end
        if (it.action == ACT_NBR) begin
            if (ke > e_high) e_high = ke;
            if (ke < e_low) e_low = ke;
            return;
        end
        if (it.action != ACT_SAMPLE) return;
        if (ke > e_mean && ke - e_mean > 1)
            ratio = quot_q16((e_high > e_mean) ? e_high - e_mean : 0, ke - e_mean,
                             64'hFFFFFF);
        else if (ke < e_mean && e_mean - ke > 1)
            ratio = quot_q16((e_mean > e_low) ? e_mean - e_low : 0, e_mean - ke,
                             64'hFFFFFF);
        else
            ratio = 65536;
        a = shape(ratio);
        if (a < alpha_run) alpha_run = a;
        if (it.energy_limit < alpha_run) alpha_run = it.energy_limit;
        eraw = 64'(unsigned'(it.total_energy));
        if (eraw == 0 || it.total_energy[31]) a = 0;
        else a = quot_q16(eraw << 16, ke + 1, 65536);
        if (a < alpha_run) alpha_run = a;
        if (npts < 8) begin
            px[npts] = x; py[npts] = y; pz[npts] = z;
            npts++;
        end
        if (!it.last) return;
        for (int i = 0; i < npts; i++) begin
            r.lim_x = 32'(mix(mx, px[i], alpha_run));
            r.lim_y = 32'(mix(my, py[i], alpha_run));
            r.lim_z = 32'(mix(mz, pz[i], alpha_run));
            r.coefficient = alpha_run[16:0];
            r.final_res = (i + 1 == npts);
            pending.push_back(r);
        end
        alpha_run = 65536;
        npts = 0;
    endfunction

    function void check_result(t_out got);
        t_out want;
        if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %p", got);
            return;
        end
        want = pending.pop_front();
        if (got !== want) begin
            errors++;
            if (errors <= 10) $display("result mismatch: expected %p actual %p", want, got);
        end
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    t_in        i_item = '0;
    logic       o_res_strobe;
    t_out       o_res;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_data = '0;

    limiter_scoreboard board = new();
    int  send_idle_pct;
    int  idle_cycles;

    always #4 i_clk = ~i_clk;

    kinetic_energy_slope_limiter_top DUT (.*);

    // results cannot be held off, so every strobe is checked at once
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_strobe) board.check_result(o_res);
    end

    // watchdog: cycles with nothing accepted
    always @(posedge i_clk) begin
        if ((start && !busy) || o_res_strobe || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // drive one item, with a random gap ahead of it
    task automatic send_item(t_in it);
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        board.note_item(it);
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait out pending results, then let a sample with no result finish
    task automatic drain();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic set_mode(logic [1:0] m);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.mode = m;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_vel();
        case ($urandom_range(3))
            0: return 32'($signed($urandom_range(8192)) - 4096) <<< 8;
            1: return $urandom();
            2: return 32'($signed($urandom_range(131072)) - 65536);
            default: return 32'($signed($urandom_range(1024)) - 512);
        endcase
    endfunction

    function automatic t_in make_item(logic [1:0] act, logic fin);
        t_in it;
        it.action = act;
        it.vel_x = rand_vel();
        it.vel_y = rand_vel();
        it.vel_z = rand_vel();
        it.total_energy = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(1 << 28);
        it.energy_limit = ($urandom_range(3) == 0) ? 17'($urandom()) : 17'(65536);
        it.last = fin;
        return it;
    endfunction

    // one well formed element: mean, neighbours, samples
    task automatic run_element(int n_smp);
        send_item(make_item(ACT_MEAN, 1'b0));
        repeat ($urandom_range(4)) send_item(make_item(ACT_NBR, 1'b0));
        for (int i = 0; i < n_smp; i++) send_item(make_item(ACT_SAMPLE, i == n_smp - 1));
    endtask

    initial begin
        t_in it;
        send_idle_pct = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: sample before any mean, extremes, special cases
        it = '0;
        it.action = ACT_SAMPLE; it.last = 1'b1;
        send_item(it);
        it = '{ACT_MEAN, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 0, 0, 0};
        send_item(it);
        it = '{ACT_NBR, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0};
        send_item(it);
        it = '{ACT_NBR, 0, 0, 0, 0, 0, 0};
        send_item(it);
        it = '{ACT_SAMPLE, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
               17'h1FFFF, 0};
        send_item(it);
        it = '{ACT_SAMPLE, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'h80000000,
               17'd65536, 0};
        send_item(it);
        it = '{2'd3, 32'h1234, 0, 0, 0, 0, 1};
        send_item(it);
        it = '{ACT_SAMPLE, 0, 0, 0, 32'hFFFFFFFF, 0, 1};
        send_item(it);
        // store overflow: ten samples in one element
        run_element(10);
        // unfinished element discarded by a new mean
        run_element(0);
        send_item(make_item(ACT_SAMPLE, 1'b0));
        run_element(3);

        for (int ph = 0; ph < 8; ph++) begin
            set_mode(2'(ph));
            case (ph % 4)
                0: send_idle_pct = 0;
                1: send_idle_pct = 83;
                2: send_idle_pct = 24;
                default: send_idle_pct = $urandom_range(50);
            endcase
            repeat (4) begin
                if ($urandom_range(9) == 0) begin
                    send_item(make_item(2'($urandom_range(3)), 1'($urandom())));
                end else begin
                    run_element($urandom_range(1, 6) + (($urandom_range(7) == 0) ? 4 : 0));
                end
            end
        end
        set_mode(MODE_NONE);
        set_mode(MODE_BJ);
        drain();

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

/* filelist.f */
rtl/kesl_pkg.sv
rtl/kesl_div.sv
rtl/kinetic_energy_slope_limiter_top.sv
tb/sv/testbench.sv
